[src/rgbhsv_pkg.sv]
package rgbhsv_pkg;

   // quotient bits produced by the divider chain, one per cell
   localparam int QuoW     = 16;
   localparam int ChanW    = 8;
   localparam int HueDivW  = 11;   // 6 * delta, at most 1530
   localparam int SatDivW  = ChanW;
   localparam int SatW     = QuoW + 1;

   typedef struct packed {
      logic [HueDivW-1:0] hue_rem;
      logic [HueDivW-1:0] hue_div;
      logic [QuoW-1:0]    hue_quo;
      logic [SatDivW-1:0] sat_rem;
      logic [SatDivW-1:0] sat_div;
      logic [QuoW-1:0]    sat_quo;
      logic               sat_full;
      logic [ChanW-1:0]   brightness;
   } hsv_work_type;

   // one restoring step of both dividers: remainder doubles, divisor
   // is taken off when it fits, quotient bit shifts in at the bottom
   function automatic hsv_work_type hsv_step(input hsv_work_type w);
      hsv_work_type     nxt;
      logic [HueDivW:0] hue_sh;
      logic [SatDivW:0] sat_sh;
      nxt    = w;
      hue_sh = {w.hue_rem, 1'b0};
      sat_sh = {w.sat_rem, 1'b0};
      if (hue_sh >= {1'b0, w.hue_div}) begin
         hue_sh      = hue_sh - {1'b0, w.hue_div};
         nxt.hue_quo = {w.hue_quo[QuoW-2:0], 1'b1};
      end else begin
         nxt.hue_quo = {w.hue_quo[QuoW-2:0], 1'b0};
      end
      if (sat_sh >= {1'b0, w.sat_div}) begin
         sat_sh      = sat_sh - {1'b0, w.sat_div};
         nxt.sat_quo = {w.sat_quo[QuoW-2:0], 1'b1};
      end else begin
         nxt.sat_quo = {w.sat_quo[QuoW-2:0], 1'b0};
      end
      nxt.hue_rem = hue_sh[HueDivW-1:0];
      nxt.sat_rem = sat_sh[SatDivW-1:0];
      return nxt;
   endfunction

endpackage

[src/rgbhsv_front.sv]
module rgbhsv_front
   import rgbhsv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [ChanW-1:0]    red,
   input  logic [ChanW-1:0]    green,
   input  logic [ChanW-1:0]    blue,
   output logic                out_valid,
   input  logic                out_ready,
   output hsv_work_type        out_data
);

   logic               valid_ff, valid_in;
   hsv_work_type       work_ff, work_in;

   logic               red_max, green_max;
   logic [ChanW-1:0]   mx, mn, delta;
   logic [HueDivW-1:0] r_w, g_w, b_w, d_w, delta6, num;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = work_ff;

   always_comb begin
      // red wins ties, then green
      red_max   = (red >= green) && (red >= blue);
      green_max = !red_max && (green >= blue);
      mx = red_max ? red : (green_max ? green : blue);
      if (red <= green && red <= blue) begin
         mn = red;
      end else if (green <= blue) begin
         mn = green;
      end else begin
         mn = blue;
      end
      delta  = mx - mn;
      r_w    = {{(HueDivW-ChanW){1'b0}}, red};
      g_w    = {{(HueDivW-ChanW){1'b0}}, green};
      b_w    = {{(HueDivW-ChanW){1'b0}}, blue};
      d_w    = {{(HueDivW-ChanW){1'b0}}, delta};
      delta6 = (d_w << 2) + (d_w << 1);
      // numerator lands in [0, 6*delta), so modular sums are exact
      if (red_max) begin
         num = (green >= blue) ? (g_w - b_w) : (delta6 + g_w - b_w);
      end else if (green_max) begin
         num = (d_w << 1) + b_w - r_w;
      end else begin
         num = (d_w << 2) + r_w - g_w;
      end

      work_in            = '0;
      work_in.brightness = mx;
      if (delta == '0) begin
         work_in.hue_rem = '0;
         work_in.hue_div = HueDivW'(1);
      end else begin
         work_in.hue_rem = num;
         work_in.hue_div = delta6;
      end
      // full saturation (min is zero) bypasses the divider
      work_in.sat_full = (mx != '0) && (mn == '0);
      if (mx == '0 || work_in.sat_full) begin
         work_in.sat_rem = '0;
         work_in.sat_div = SatDivW'(1);
      end else begin
         work_in.sat_rem = delta;
         work_in.sat_div = mx;
      end

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

endmodule

[src/rgbhsv_div_cell.sv]
module rgbhsv_div_cell
   import rgbhsv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  hsv_work_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output hsv_work_type out_data
);

   logic         valid_ff, valid_in;
   hsv_work_type work_ff, work_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = work_ff;

   always_comb begin
      work_in  = hsv_step(in_data);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

endmodule

[src/rgb_to_hsv_converter_unit.sv]
// RGB to HSV converter, one 8-bit RGB pixel in, one HSV item out.
// req channel: req_valid/req_ready with req_red, req_green, req_blue.
// rsp channel: rsp_valid/rsp_ready with rsp_hue (turn * 65536),
//   rsp_saturation (65536 = 1.0) and rsp_brightness (largest channel).
// An item moves when valid and ready are both high at a rising edge.
// Structure: a front stage finds max/min, sector and the two divisions'
// operands; then a chain of 16 identical cells, each doing one restoring
// step of both the hue and the saturation division (one quotient bit).
// Stages: 17 register stages, the front capturing at the accepting edge,
// then each cell in turn; a stall holds an item in its stage.
// Throughput: one item per clock while rsp_ready is high; every stage
// has its own valid bit and ready = stage empty or downstream taking,
// so the chain keeps filling bubbles while the receiver stalls. With
// rsp_ready low the chain holds up to 17 items before req_ready drops.
// Reset (synchronous, active high) clears all stage valid bits; items in
// flight are dropped, payload registers are not cleared.
module rgb_to_hsv_converter_unit
   import rgbhsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ChanW-1:0]  req_red,
   input  logic [ChanW-1:0]  req_green,
   input  logic [ChanW-1:0]  req_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [QuoW-1:0]   rsp_hue,
   output logic [SatW-1:0]   rsp_saturation,
   output logic [ChanW-1:0]  rsp_brightness
);

   // stage 0 is the front stage, stage k the k-th divider cell
   logic         stg_valid [0:QuoW];
   logic         stg_ready [0:QuoW];
   hsv_work_type stg_data  [0:QuoW];

   rgbhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   for (genvar k = 0; k < QuoW; k++) begin : g_cell
      rgbhsv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_data   (stg_data[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_data  (stg_data[k+1])
      );
   end

   // last cell is the output register
   assign stg_ready[QuoW] = rsp_ready;
   assign rsp_valid       = stg_valid[QuoW];
   assign rsp_hue         = stg_data[QuoW].hue_quo;
   // full saturation forced the divider to zero, so this is exact
   assign rsp_saturation  = {stg_data[QuoW].sat_full, stg_data[QuoW].sat_quo};
   assign rsp_brightness  = stg_data[QuoW].brightness;

`ifndef ASSERT_OFF
   // saturation never exceeds 1.0
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_saturation[QuoW] && rsp_saturation[QuoW-1:0] != '0))
      else $error("saturation above 1.0");

   // grey pixel: no saturation means no hue
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturation == '0) |-> rsp_hue == '0)
      else $error("hue nonzero on grey pixel");

   // black pixel has zero saturation
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brightness == '0) |-> rsp_saturation == '0)
      else $error("saturation nonzero on black pixel");

   // an empty output stage lets the whole chain advance
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");
`endif

endmodule
